FILE: design/dspm_pkg.sv
`timescale 1ns / 1ps

package dspm_pkg;

   // item action codes
   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_TEXT = 2'd1;
   localparam logic [1:0] ACT_END  = 2'd2;

   // pattern metacharacters
   localparam logic [7:0] DOT_BYTE  = 8'h2E;
   localparam logic [7:0] STAR_BYTE = 8'h2A;

   // broadcast control from the top level to every cell
   typedef struct packed {
      logic       rearm;
      logic       text;
      logic [7:0] symbol;
   } ctl_type;

   // what one cell presents to its neighbours and to the top level
   typedef struct packed {
      logic active;
      logic closed;
      logic is_star;
      logic close_out;
      logic adv_out;
   } cell_out_type;

endpackage

FILE: design/dspm_cell.sv
`timescale 1ns / 1ps

module dspm_cell #(
   parameter int INDEX = 0,
   parameter int LEN_W = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dspm_pkg::ctl_type     ctl,
   input  logic                  wr_en,
   input  logic [LEN_W-1:0]      len,
   input  logic                  star_next,
   input  logic                  close_in,
   input  logic                  adv_in,
   output dspm_pkg::cell_out_type cell_out
);
   import dspm_pkg::*;

   logic [7:0] byte_ff;
   logic       act_ff;
   logic       act_in;
   logic       used;
   logic       starred;
   logic       closed;
   logic       hit;

   // pattern byte held by this position
   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_ff <= ctl.symbol;
      end
   end

   // element flags: inside the pattern, and followed by a star
   assign used    = LEN_W'(INDEX) < len;
   assign starred = star_next && (LEN_W'(INDEX + 1) < len);

   // position reached directly or by skipping a starred element two back
   assign closed = act_ff || close_in;
   assign hit    = closed && used && (byte_ff == ctl.symbol || byte_ff == DOT_BYTE);

   // on text, stay on a starred match or advance from the left; rearm arms cell 0
   always_comb begin
      act_in = act_ff;
      if (ctl.rearm) begin
         act_in = (INDEX == 0);
      end else if (ctl.text) begin
         act_in = (hit && starred) || adv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= (INDEX == 0);
      end else begin
         act_ff <= act_in;
      end
   end

   assign cell_out.active    = act_ff;
   assign cell_out.closed    = closed;
   assign cell_out.is_star   = (byte_ff == STAR_BYTE);
   assign cell_out.close_out = closed && starred;
   assign cell_out.adv_out   = hit && !starred;

endmodule

FILE: design/dot_star_pattern_matcher.sv
`timescale 1ns / 1ps
// channel | direction | ports                                   | handshake
// req     | in        | req_action, req_symbol, req_first       | req_valid / req_ready
// rsp     | out       | rsp_matched, rsp_overflow               | rsp_valid / rsp_ready
//
// a new item is taken whenever req_ready is high: a row of position cells updates all active bits at
// once, and the star-skip closure ripples through the row like a carry chain.
// an end-of-text item writes its result into the output register when it is accepted.
// reset clears the pattern length, the overflow flag and arms position zero.
// req_ready drops only while a result waits in the output register and rsp_ready is low.

module dot_star_pattern_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_symbol,
   input  logic       req_first,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_overflow
);
   import dspm_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic                   req_acc;
   logic                   load_acc;
   logic                   end_acc;
   ctl_type                ctl;
   logic [LEN_W-1:0]       len_ff;
   logic [LEN_W-1:0]       len_in;
   logic                   ovf_ff;
   logic                   ovf_in;
   logic [LEN_W-1:0]       wr_base;
   logic                   room;
   logic                   tail_ff;
   logic                   tail_in;
   logic                   tail_closed;
   logic [MAX_PATTERN:0]   closed_vec;
   logic [MAX_PATTERN:0]   act_vec;
   cell_out_type           outs [MAX_PATTERN];
   logic                   rsp_valid_ff;
   logic                   rsp_matched_ff;
   logic                   rsp_overflow_ff;

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_acc   = req_valid && req_ready;
   assign load_acc  = req_acc && (req_action == ACT_LOAD);
   assign end_acc   = req_acc && (req_action == ACT_END);

   assign ctl.rearm  = load_acc || end_acc;
   assign ctl.text   = req_acc && (req_action == ACT_TEXT);
   assign ctl.symbol = req_symbol;

   // pattern length and overflow bookkeeping
   assign wr_base = req_first ? '0 : len_ff;
   assign room    = wr_base < LEN_W'(MAX_PATTERN);

   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (load_acc) begin
         if (req_first) begin
            ovf_in = 1'b0;
         end
         if (room) begin
            len_in = wr_base + LEN_W'(1);
         end else begin
            len_in = wr_base;
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   // row of position cells
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic close_in;
      logic adv_in;
      logic star_next;
      logic wr_en;

      if (j >= 2) begin : g_close
         assign close_in = outs[j-2].close_out;
      end else begin : g_close_none
         assign close_in = 1'b0;
      end

      if (j >= 1) begin : g_adv
         assign adv_in = outs[j-1].adv_out;
      end else begin : g_adv_none
         assign adv_in = 1'b0;
      end

      if (j + 1 < MAX_PATTERN) begin : g_star
         assign star_next = outs[j+1].is_star;
      end else begin : g_star_none
         assign star_next = 1'b0;
      end

      assign wr_en = load_acc && room && (wr_base == LEN_W'(j));

      dspm_cell #(
         .INDEX (j),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .wr_en     (wr_en),
         .len       (len_ff),
         .star_next (star_next),
         .close_in  (close_in),
         .adv_in    (adv_in),
         .cell_out  (outs[j])
      );

      assign closed_vec[j] = outs[j].closed;
      assign act_vec[j]    = outs[j].active;
   end

   // final position past the last pattern store cell
   assign tail_closed = tail_ff || outs[MAX_PATTERN-2].close_out;

   always_comb begin
      tail_in = tail_ff;
      if (ctl.rearm) begin
         tail_in = 1'b0;
      end else if (ctl.text) begin
         tail_in = outs[MAX_PATTERN-1].adv_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= 1'b0;
      end else begin
         tail_ff <= tail_in;
      end
   end

   assign closed_vec[MAX_PATTERN] = tail_closed;
   assign act_vec[MAX_PATTERN]    = tail_ff;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (end_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (end_acc) begin
         rsp_matched_ff  <= closed_vec[len_ff] && !ovf_ff;
         rsp_overflow_ff <= ovf_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_matched  = rsp_matched_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // checks
   a_ovf_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_matched)
      else $error("match reported together with overflow");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> act_vec == (MAX_PATTERN + 1)'(1))
      else $error("position set not rearmed after pattern load");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_PATTERN))
      else $error("pattern length beyond store");

   a_empty_text: assert property (@(posedge clock) disable iff (reset)
      ctl.text && len_ff == '0 |=> act_vec == '0)
      else $error("empty pattern kept an active position after a text byte");

endmodule
